FILE: rtl/core/olir_pkg.sv
// Shared types and codes for the ordered list block.
// Holds operation and status codes, transfer structs and the cell command bus.
// No dependencies.
package olir_pkg;

   // Default sizes handed to the top level parameters.
   localparam int DEFAULT_DEPTH = 64;
   localparam int DEFAULT_WIDTH = 32;

   // Position width on the cell command bus; covers counts up to 1024.
   localparam int POS_W = 11;

   // Operation codes.
   localparam logic [1:0] KIND_APPEND  = 2'd0;
   localparam logic [1:0] KIND_INSERT  = 2'd1;
   localparam logic [1:0] KIND_REMOVE  = 2'd2;
   localparam logic [1:0] KIND_REPLACE = 2'd3;

   // Status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // One request transfer.
   typedef struct packed {
      logic [1:0]         kind;
      logic [5:0]         index;
      logic signed [31:0] value;
   } req_type;

   // One response transfer.
   typedef struct packed {
      logic [1:0]         status;
      logic [6:0]         count;
      logic signed [31:0] element;
   } rsp_type;

   // Command broadcast to every cell in the row.
   typedef struct packed {
      logic             upd;     // operation is accepted and legal
      logic [1:0]       kind;
      logic [POS_W-1:0] target;  // index, or the count for append
   } cmd_type;

endpackage

FILE: rtl/core/olir_cell.sv
// One storage cell of the ordered list row.
// Depends on olir_pkg for the command bus type and operation codes.
// Holds one word and takes it from the command, its left or its right neighbor.
module olir_cell #(
   parameter int WIDTH = olir_pkg::DEFAULT_WIDTH,
   parameter int POS   = 0
) (
   input  logic                 clock,
   input  olir_pkg::cmd_type    cmd,
   input  logic [WIDTH-1:0]     value,
   input  logic [WIDTH-1:0]     left_word,
   input  logic [WIDTH-1:0]     right_word,
   output logic [WIDTH-1:0]     word,
   output logic [WIDTH-1:0]     tap
);

   localparam logic [olir_pkg::POS_W-1:0] MY_POS = olir_pkg::POS_W'(POS);

   logic [WIDTH-1:0] word_ff;
   logic [WIDTH-1:0] word_in;
   logic             hit;
   logic             above;

   assign hit   = (cmd.target == MY_POS);
   assign above = (MY_POS > cmd.target);

   // Next word: load at the target, shift up above it on insert, down from it on remove.
   always_comb begin
      word_in = word_ff;
      if (cmd.upd) begin
         case (cmd.kind)
            olir_pkg::KIND_APPEND,
            olir_pkg::KIND_REPLACE: begin
               if (hit) word_in = value;
            end
            olir_pkg::KIND_INSERT: begin
               if (hit) word_in = value;
               else if (above) word_in = left_word;
            end
            olir_pkg::KIND_REMOVE: begin
               if (hit || above) word_in = right_word;
            end
            default: begin
               word_in = word_ff;
            end
         endcase
      end
   end

   // Payload register; no reset needed.
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

   // Word offered to the read-out tree only when this cell is the target.
   assign tap = hit ? word_ff : '0;

endmodule

FILE: rtl/core/ordered_list_insert_remove.sv
// Top level of the ordered list block: a row of storage cells plus control.
// Depends on olir_pkg and olir_cell.
//
//   channel   ports                      direction  transfer marked by
//   request   start, busy, req           in         start high and busy low
//   response  rsp_valid, rsp             out        rsp_valid high, one cycle
//
// Busy stays low, so a new request can be taken at every clock edge. The
// response appears in the cycle after the request transfer. All cells shift
// together at the edge that takes the request, and the removed or overwritten
// word is picked by an OR tree over the cell taps.
// Reset clears the element count and the response strobe; cell contents are
// not cleared, since only written cells below the count are ever read.
// The receiver cannot stall the response.
module ordered_list_insert_remove #(
   parameter int DEPTH = olir_pkg::DEFAULT_DEPTH,
   parameter int WIDTH = olir_pkg::DEFAULT_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  olir_pkg::req_type req,
   output logic              rsp_valid,
   output olir_pkg::rsp_type rsp
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = olir_pkg::POS_W;

   logic [CW-1:0]          used_ff;
   logic [CW-1:0]          used_in;
   logic                   rsp_valid_ff;
   olir_pkg::rsp_type      rsp_ff;
   olir_pkg::rsp_type      rsp_in;
   olir_pkg::cmd_type      cmd;
   logic                   accept;
   logic [PW-1:0]          idx_ext;
   logic [PW-1:0]          used_ext;
   logic                   full;
   logic [1:0]             status;
   logic [WIDTH-1:0]       value_w;
   logic [WIDTH-1:0]       sel_word;
   logic signed [31:0]     sel_elem;
   logic [WIDTH-1:0]       words [DEPTH];
   logic [WIDTH-1:0]       taps  [DEPTH];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign idx_ext  = PW'(req.index);
   assign used_ext = PW'(used_ff);
   assign full     = (used_ff == CW'(DEPTH));

   // Convert the 32-bit request value to the stored width, and the stored word back.
   generate
      if (WIDTH > 32) begin : g_wide
         assign value_w  = {{(WIDTH-32){req.value[31]}}, req.value};
         assign sel_elem = sel_word[31:0];
      end else if (WIDTH == 32) begin : g_same
         assign value_w  = req.value;
         assign sel_elem = sel_word;
      end else begin : g_narrow
         assign value_w  = req.value[WIDTH-1:0];
         assign sel_elem = {{(32-WIDTH){sel_word[WIDTH-1]}}, sel_word};
      end
   endgenerate

   // Status check for the requested operation.
   always_comb begin
      status = olir_pkg::ST_OK;
      case (req.kind)
         olir_pkg::KIND_APPEND: begin
            if (full) status = olir_pkg::ST_FULL;
         end
         olir_pkg::KIND_INSERT: begin
            if (idx_ext > used_ext) status = olir_pkg::ST_RANGE;
            else if (full) status = olir_pkg::ST_FULL;
         end
         olir_pkg::KIND_REMOVE,
         olir_pkg::KIND_REPLACE: begin
            if (idx_ext >= used_ext) status = olir_pkg::ST_RANGE;
         end
         default: begin
            status = olir_pkg::ST_OK;
         end
      endcase
   end

   // Command broadcast to the cell row.
   always_comb begin
      cmd.upd    = accept && (status == olir_pkg::ST_OK);
      cmd.kind   = req.kind;
      cmd.target = (req.kind == olir_pkg::KIND_APPEND) ? used_ext : idx_ext;
   end

   // The row of cells; each sees its two neighbors.
   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         logic [WIDTH-1:0] left_w;
         logic [WIDTH-1:0] right_w;
         if (i == 0) begin : g_first
            assign left_w = '0;
         end else begin : g_left
            assign left_w = words[i-1];
         end
         if (i == DEPTH - 1) begin : g_last
            assign right_w = '0;
         end else begin : g_right
            assign right_w = words[i+1];
         end
         olir_cell #(
            .WIDTH (WIDTH),
            .POS   (i)
         ) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .value      (value_w),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (words[i]),
            .tap        (taps[i])
         );
      end
   endgenerate

   // Only the target cell drives a nonzero tap, so OR picks it out.
   always_comb begin
      sel_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         sel_word = sel_word | taps[i];
      end
   end

   // Next count.
   always_comb begin
      used_in = used_ff;
      if (cmd.upd) begin
         case (req.kind)
            olir_pkg::KIND_APPEND,
            olir_pkg::KIND_INSERT: used_in = used_ff + CW'(1);
            olir_pkg::KIND_REMOVE: used_in = used_ff - CW'(1);
            default:               used_in = used_ff;
         endcase
      end
   end

   // Response payload; element only for a legal remove or replace.
   always_comb begin
      rsp_in.status  = status;
      rsp_in.count   = 7'(used_in);
      rsp_in.element = '0;
      if (status == olir_pkg::ST_OK &&
          (req.kind == olir_pkg::KIND_REMOVE || req.kind == olir_pkg::KIND_REPLACE)) begin
         rsp_in.element = sel_elem;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) used_ff <= used_in;
         rsp_valid_ff <= accept;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (accept) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

FILE: rtl/core/olir_checker.sv
// Port-level checks for the ordered list block, bound to its top level.
// Depends on olir_pkg and ordered_list_insert_remove.
module olir_checker #(
   parameter int DEPTH = olir_pkg::DEFAULT_DEPTH
) (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input olir_pkg::req_type req,
   input logic              rsp_valid,
   input olir_pkg::rsp_type rsp
);

   // Every response comes from a request transfer in the cycle before.
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy))
      else $error("response without a request transfer");

   // A failed operation never returns an element.
   a_err_no_elem: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status != olir_pkg::ST_OK |-> rsp.element == 32'sd0)
      else $error("element returned on a failed operation");

   // Append and insert never return an element.
   a_add_no_elem: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ($past(req.kind) == olir_pkg::KIND_APPEND ||
                    $past(req.kind) == olir_pkg::KIND_INSERT) |-> rsp.element == 32'sd0)
      else $error("element returned on append or insert");

   // A full report only comes with a full list.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status == olir_pkg::ST_FULL |-> rsp.count == 7'(DEPTH))
      else $error("full status with a list that is not full");

endmodule

bind ordered_list_insert_remove olir_checker #(
   .DEPTH (DEPTH)
) u_olir_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp       (rsp)
);

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ordered list block: directed and random operations.
// Depends on olir_pkg and ordered_list_insert_remove.
module tb;
   import olir_pkg::*;

   localparam int DEPTH = DEFAULT_DEPTH;

   // One pending request and the sender idle chance that goes with it.
   typedef struct {
      req_type item;
      int      idle;
   } backlog_entry;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp;

   backlog_entry req_backlog[$];
   rsp_type      rsp_due[$];
   int           mismatches = 0;

   // Shadow copy of the list that the responses are predicted from.
   logic signed [31:0] list_words [DEPTH];
   int                 list_len = 0;

   // Element count seen by the stimulus generator, ahead of the driver.
   int plan_count = 0;
   bit filling = 1'b1;
   int linger = 3;

   ordered_list_insert_remove uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one accepted request to the shadow list and queue its response.
   task automatic list_apply(input req_type r);
      rsp_type o;
      int      pos;
      int      i;
      o.status = ST_OK;
      o.element = '0;
      pos = int'(r.index);
      case (r.kind)
         KIND_APPEND: begin
            if (list_len >= DEPTH) begin
               o.status = ST_FULL;
            end else begin
               list_words[list_len] = r.value;
               list_len++;
            end
         end
         KIND_INSERT: begin
            if (pos > list_len) begin
               o.status = ST_RANGE;
            end else if (list_len >= DEPTH) begin
               o.status = ST_FULL;
            end else begin
               for (i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
               list_words[pos] = r.value;
               list_len++;
            end
         end
         KIND_REMOVE: begin
            if (pos >= list_len) begin
               o.status = ST_RANGE;
            end else begin
               o.element = list_words[pos];
               for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
               list_len--;
            end
         end
         default: begin
            if (pos >= list_len) begin
               o.status = ST_RANGE;
            end else begin
               o.element = list_words[pos];
               list_words[pos] = r.value;
            end
         end
      endcase
      o.count = 7'(list_len);
      rsp_due.push_back(o);
   endtask

   // Queue one request and track the count it leaves behind.
   task automatic queue_op(input logic [1:0] kind, input logic [5:0] pos,
                           input logic [31:0] value, input int idle);
      backlog_entry e;
      e.item.kind = kind;
      e.item.index = pos;
      e.item.value = value;
      e.idle = idle;
      req_backlog.push_back(e);
      case (kind)
         KIND_APPEND: if (plan_count < DEPTH) plan_count++;
         KIND_INSERT: if (int'(pos) <= plan_count && plan_count < DEPTH) plan_count++;
         KIND_REMOVE: if (int'(pos) < plan_count) plan_count--;
         default: ;
      endcase
   endtask

   // One random request. The mix swings between filling and draining the
   // list so that both the full and the empty list are reached often.
   task automatic plan_random(input int idle);
      logic [1:0]  kind;
      logic [5:0]  pos;
      logic [31:0] value;
      int          roll;
      roll = $urandom_range(99);
      if (roll < 8) begin
         kind = 2'($urandom);
         pos = 6'($urandom);
      end else begin
         roll = $urandom_range(99);
         if (filling) begin
            kind = roll < 45 ? KIND_APPEND : roll < 80 ? KIND_INSERT :
                   roll < 90 ? KIND_REPLACE : KIND_REMOVE;
         end else begin
            kind = roll < 55 ? KIND_REMOVE : roll < 72 ? KIND_REPLACE :
                   roll < 84 ? KIND_APPEND : KIND_INSERT;
         end
         roll = $urandom_range(99);
         if (roll < 85) begin
            // Mostly a legal position for the current count.
            if (kind == KIND_INSERT || kind == KIND_APPEND) begin
               pos = 6'($urandom_range(plan_count < DEPTH ? plan_count : DEPTH - 1));
            end else if (plan_count > 0) begin
               pos = 6'($urandom_range(plan_count - 1));
            end else begin
               pos = 6'($urandom);
            end
         end else if (roll < 93 && plan_count < DEPTH) begin
            // Position right at the end of the list.
            pos = 6'(plan_count);
         end else begin
            pos = 6'($urandom);
         end
      end
      roll = $urandom_range(99);
      case (roll % 10)
         0: value = roll < 50 ? 32'h7fff_ffff : 32'h8000_0000;
         1: value = roll < 50 ? 32'h0000_0000 : 32'hffff_ffff;
         default: value = $urandom;
      endcase
      queue_op(kind, pos, value, idle);
      // Stay a few items at a full or empty list, then turn around.
      if ((filling && plan_count == DEPTH) || (!filling && plan_count == 0)) begin
         linger--;
         if (linger <= 0) begin
            filling = !filling;
            linger = $urandom_range(1, 6);
         end
      end else if ($urandom_range(99) == 0) begin
         filling = !filling;
      end
   endtask

   // Driver: record each transfer, then present the next request or idle.
   always @(posedge clock) begin : drive_proc
      logic took;
      took = start && !busy;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (took) begin
            list_apply(req);
            void'(req_backlog.pop_front());
         end
         if (start && !took) begin
            // Hold the request until the block takes it.
         end else if (req_backlog.size() != 0 &&
                      $urandom_range(99) >= req_backlog[0].idle) begin
            start <= 1'b1;
            req <= req_backlog[0].item;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: compare every response strobe with the oldest prediction.
   always @(posedge clock) begin : check_proc
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (rsp_due.size() == 0) begin
            $display("%0t: response with none expected: status %0d count %0d element %0d",
                     $time, rsp.status, rsp.count, rsp.element);
            mismatches++;
         end else begin
            want = rsp_due.pop_front();
            if (rsp.status !== want.status) begin
               $display("%0t: status expected %0d got %0d", $time, want.status, rsp.status);
               mismatches++;
            end
            if (rsp.count !== want.count) begin
               $display("%0t: count expected %0d got %0d", $time, want.count, rsp.count);
               mismatches++;
            end
            if (rsp.element !== want.element) begin
               $display("%0t: element expected %0d got %0d",
                        $time, want.element, rsp.element);
               mismatches++;
            end
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin : main_proc
      int n;
      // Empty list: every indexed operation is out of range.
      queue_op(KIND_REMOVE, 6'd0, 32'd5, 0);
      queue_op(KIND_REPLACE, 6'd0, 32'd5, 0);
      queue_op(KIND_INSERT, 6'd1, 32'd5, 0);
      // Insert at the count acts as append; then appends of extreme values.
      queue_op(KIND_INSERT, 6'd0, 32'h7fff_ffff, 0);
      queue_op(KIND_APPEND, 6'd17, 32'h8000_0000, 0);
      queue_op(KIND_APPEND, 6'd63, 32'h0000_0000, 0);
      queue_op(KIND_APPEND, 6'd0, 32'hffff_ffff, 30);
      // Inserts in the middle and at the head.
      queue_op(KIND_INSERT, 6'd2, 32'd12345, 0);
      queue_op(KIND_INSERT, 6'd0, -32'sd7, 0);
      queue_op(KIND_REPLACE, 6'd3, 32'h5a5a_5a5a, 0);
      // Index equal to the count for replace and remove, above it for insert.
      queue_op(KIND_REPLACE, 6'd6, 32'h1234_5678, 0);
      queue_op(KIND_REMOVE, 6'd6, 32'h0, 50);
      queue_op(KIND_INSERT, 6'd7, 32'h0, 0);
      queue_op(KIND_INSERT, 6'd6, 32'd99, 0);
      // Remove at the head and at the tail.
      queue_op(KIND_REMOVE, 6'd0, 32'h0, 0);
      queue_op(KIND_REMOVE, 6'd5, 32'hffff_ffff, 0);
      queue_op(KIND_REPLACE, 6'd63, 32'h0, 0);
      queue_op(KIND_REMOVE, 6'd63, 32'h0, 0);
      queue_op(KIND_APPEND, 6'd0, 32'h0000_0001, 0);
      queue_op(KIND_REMOVE, 6'd2, 32'h0, 0);

      // Random phases: no gaps, heavy sender gaps, no gaps, light gaps.
      for (n = 0; n < 1950; n++) begin
         case (n / 488)
            1: plan_random(81);
            3: plan_random(24);
            default: plan_random(0);
         endcase
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || rsp_due.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog for a hung handshake or a missing response.
   initial begin : watchdog_proc
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
